@@ rtl/fe2eq_pkg.sv @@
// ============================================================================
// fe2eq_pkg
// Shared constants, types and tables for the fisheye-to-equirectangular
// remap coordinate generator.
// ============================================================================
package fe2eq_pkg;

    // Field widths
    localparam int COORD_BITS    = 13;
    localparam int FRAC_BITS     = 4;
    localparam int OUT_BITS      = 18;
    localparam int S_TDATA_BITS  = 32;
    localparam int M_TDATA_BITS  = 40;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 14;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MAP_COLUMNS = 3'd0,
        REG_MAP_ROWS    = 3'd1,
        REG_SPAN_WIDTH  = 3'd2,
        REG_SPAN_HEIGHT = 3'd3,
        REG_CROP_MARGIN = 3'd4
    } cfg_reg_t;

    // Pipeline depths
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 32;
    localparam int SQRT_STEPS   = 32;
    localparam int RECIP_STEPS  = 3;
    localparam int LATENCY      = 166;

    // Q30 constants
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
    localparam logic [31:0] KINV_Q30     = 32'd652032874;
    localparam logic [31:0] ONE_HALF_Q30 = 32'd536870912;

    // floor(2^62 / PI_Q30): reciprocal of pi for the radius normalisation
    localparam logic [30:0] INV_PI_Q62   = 31'd1367130551;

    // atan(2^-i) in Q30 radians
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
        32'd32,        32'd16,        32'd8,         32'd4,         32'd2
    };

    // Direction components carried alongside the square root
    typedef struct packed {
        logic signed [33:0] sx;
        logic signed [33:0] sy;
        logic signed [33:0] sz;
    } dir_t;

    // Direction and radius carried alongside the arc tangent
    typedef struct packed {
        logic signed [33:0] sx;
        logic signed [33:0] sz;
        logic [31:0]        rho;
    } dir_rho_t;

    // Sign flags carried alongside the quotients
    typedef struct packed {
        logic neg_c;
        logic neg_s;
        logic rho_zero;
    } sign_t;

endpackage

@@ rtl/fe2eq_div.sv @@
// ============================================================================
// fe2eq_div
// Pipelined restoring divider: 64-bit dividend over 32-bit divisor, one
// quotient bit per stage. The quotient must fit in 32 bits.
// ============================================================================
module fe2eq_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic [31:0] quo
);
    import fe2eq_pkg::*;

    logic [31:0] rem_reg [DIV_STEPS];
    logic [31:0] low_reg [DIV_STEPS];
    logic [31:0] den_reg [DIV_STEPS];
    logic [31:0] quo_reg [DIV_STEPS];

    logic [31:0] rem_src [DIV_STEPS];
    logic [31:0] low_src [DIV_STEPS];
    logic [31:0] den_src [DIV_STEPS];
    logic [31:0] quo_src [DIV_STEPS];

    logic [31:0] rem_next [DIV_STEPS];
    logic [31:0] low_next [DIV_STEPS];
    logic [31:0] quo_next [DIV_STEPS];

    // Stage inputs: first stage from the ports, the rest from the stage before
    always_comb
    begin
        rem_src[0] = num[63:32];
        low_src[0] = num[31:0];
        den_src[0] = den;
        quo_src[0] = '0;
        for (int i = 1; i < DIV_STEPS; i++)
        begin
            rem_src[i] = rem_reg[i-1];
            low_src[i] = low_reg[i-1];
            den_src[i] = den_reg[i-1];
            quo_src[i] = quo_reg[i-1];
        end
    end

    // One trial subtraction per stage
    always_comb
    begin
        logic [32:0] trial;
        logic        ge;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial = {rem_src[i], low_src[i][31]};
            ge    = (trial >= {1'b0, den_src[i]});
            if (ge)
                rem_next[i] = 32'(trial - {1'b0, den_src[i]});
            else
                rem_next[i] = trial[31:0];
            low_next[i] = {low_src[i][30:0], 1'b0};
            quo_next[i] = {quo_src[i][30:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            den_reg <= den_src;
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

@@ rtl/fe2eq_rot.sv @@
// ============================================================================
// fe2eq_rot
// Pipelined rotation CORDIC: cosine and sine in Q30 of an angle in [0, pi),
// one micro-rotation per stage.
// ============================================================================
module fe2eq_rot (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        angle,
    output logic signed [33:0] cos_out,
    output logic signed [33:0] sin_out
);
    import fe2eq_pkg::*;

    logic signed [33:0] x_reg [CORDIC_STEPS];
    logic signed [33:0] y_reg [CORDIC_STEPS];
    logic signed [33:0] z_reg [CORDIC_STEPS];

    logic signed [33:0] x_src [CORDIC_STEPS];
    logic signed [33:0] y_src [CORDIC_STEPS];
    logic signed [33:0] z_src [CORDIC_STEPS];

    logic signed [33:0] x_next [CORDIC_STEPS];
    logic signed [33:0] y_next [CORDIC_STEPS];
    logic signed [33:0] z_next [CORDIC_STEPS];

    // Start on the y axis at the gain-corrected length, angle offset by pi/2
    always_comb
    begin
        x_src[0] = '0;
        y_src[0] = $signed({2'b00, KINV_Q30});
        z_src[0] = $signed({2'b00, angle}) - $signed({2'b00, HALF_PI_Q30});
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            x_src[i] = x_reg[i-1];
            y_src[i] = y_reg[i-1];
            z_src[i] = z_reg[i-1];
        end
    end

    // Micro-rotations
    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!z_src[i][33])
            begin
                x_next[i] = x_src[i] - (y_src[i] >>> i);
                y_next[i] = y_src[i] + (x_src[i] >>> i);
                z_next[i] = z_src[i] - $signed({2'b00, ATAN_TAB[i]});
            end
            else
            begin
                x_next[i] = x_src[i] + (y_src[i] >>> i);
                y_next[i] = y_src[i] - (x_src[i] >>> i);
                z_next[i] = z_src[i] + $signed({2'b00, ATAN_TAB[i]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign cos_out = x_reg[CORDIC_STEPS-1];
    assign sin_out = y_reg[CORDIC_STEPS-1];

endmodule

@@ rtl/fe2eq_sqrt.sv @@
// ============================================================================
// fe2eq_sqrt
// Pipelined floor integer square root of a 64-bit value, one result bit
// per stage.
// ============================================================================
module fe2eq_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);
    import fe2eq_pkg::*;

    logic [63:0] v_reg   [SQRT_STEPS];
    logic [63:0] res_reg [SQRT_STEPS];

    logic [63:0] v_src   [SQRT_STEPS];
    logic [63:0] res_src [SQRT_STEPS];
    logic [63:0] v_next   [SQRT_STEPS];
    logic [63:0] res_next [SQRT_STEPS];

    always_comb
    begin
        v_src[0]   = radicand;
        res_src[0] = '0;
        for (int i = 1; i < SQRT_STEPS; i++)
        begin
            v_src[i]   = v_reg[i-1];
            res_src[i] = res_reg[i-1];
        end
    end

    // Digit-by-digit step, trial bit moving down two places per stage
    always_comb
    begin
        logic [63:0] bitv;
        logic [63:0] trial;
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            bitv  = 64'd1 << (62 - 2 * i);
            trial = res_src[i] + bitv;
            if (v_src[i] >= trial)
            begin
                v_next[i]   = v_src[i] - trial;
                res_next[i] = (res_src[i] >> 1) + bitv;
            end
            else
            begin
                v_next[i]   = v_src[i];
                res_next[i] = res_src[i] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= v_next;
            res_reg <= res_next;
        end
    end

    assign root = res_reg[SQRT_STEPS-1][31:0];

endmodule

@@ rtl/fe2eq_vec.sv @@
// ============================================================================
// fe2eq_vec
// Pipelined vectoring CORDIC: angle of (x, y) with y >= 0 in [0, pi], Q30.
// One pre-rotation stage for x < 0, then one micro-rotation per stage.
// ============================================================================
module fe2eq_vec (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        y_in,
    input  logic signed [33:0] x_in,
    output logic [32:0]        alpha
);
    import fe2eq_pkg::*;

    logic signed [35:0] pre_x_reg;
    logic signed [35:0] pre_y_reg;
    logic signed [33:0] pre_z_reg;

    logic signed [35:0] x_reg [CORDIC_STEPS];
    logic signed [35:0] y_reg [CORDIC_STEPS];
    logic signed [33:0] z_reg [CORDIC_STEPS];

    logic signed [35:0] x_src [CORDIC_STEPS];
    logic signed [35:0] y_src [CORDIC_STEPS];
    logic signed [33:0] z_src [CORDIC_STEPS];

    logic signed [35:0] x_next [CORDIC_STEPS];
    logic signed [35:0] y_next [CORDIC_STEPS];
    logic signed [33:0] z_next [CORDIC_STEPS];

    logic signed [33:0] z_last;

    // Left half-plane: rotate by -pi/2 first
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in[33])
            begin
                pre_x_reg <= $signed({4'b0000, y_in});
                pre_y_reg <= -36'(x_in);
                pre_z_reg <= $signed({2'b00, HALF_PI_Q30});
            end
            else
            begin
                pre_x_reg <= 36'(x_in);
                pre_y_reg <= $signed({4'b0000, y_in});
                pre_z_reg <= '0;
            end
        end
    end

    always_comb
    begin
        x_src[0] = pre_x_reg;
        y_src[0] = pre_y_reg;
        z_src[0] = pre_z_reg;
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            x_src[i] = x_reg[i-1];
            y_src[i] = y_reg[i-1];
            z_src[i] = z_reg[i-1];
        end
    end

    // Drive y towards zero
    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y_src[i] > 0)
            begin
                x_next[i] = x_src[i] + (y_src[i] >>> i);
                y_next[i] = y_src[i] - (x_src[i] >>> i);
                z_next[i] = z_src[i] + $signed({2'b00, ATAN_TAB[i]});
            end
            else
            begin
                x_next[i] = x_src[i] - (y_src[i] >>> i);
                y_next[i] = y_src[i] + (x_src[i] >>> i);
                z_next[i] = z_src[i] - $signed({2'b00, ATAN_TAB[i]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // Negative residue clamps to zero
    assign z_last = z_reg[CORDIC_STEPS-1];
    assign alpha  = z_last[33] ? '0 : z_last[32:0];

endmodule

@@ rtl/fisheye_to_equirect_map_gen.sv @@
// ============================================================================
// fisheye_to_equirect_map_gen
// Remap coordinate generator: map position in, fisheye source position out.
// ============================================================================
// Usage:
//   s_* stream carries one map position per transfer, m_* stream returns the
//   matching fisheye source coordinate (signed, 1/16 pixel) in the same order.
//   Sizes, spans and crop are set on the cfg_* write port while the block is
//   idle; a write takes effect at once.
//   Throughput is one transfer per clock while the receiver is not stalling.
//   The pipeline is a chain of two 32-stage dividers, a 30-stage sine/cosine
//   CORDIC, a 32-stage square root, a 31-stage arc tangent CORDIC and the
//   clamp, multiply and rounding stages.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops; nothing is dropped or repeated.
//   Reset empties the pipeline and loads the register defaults: 1024 columns,
//   1024 rows, spans of 1024 and no crop.
// ============================================================================
module fisheye_to_equirect_map_gen (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // cfg: register index and data, written when cfg_write is high
    input  logic                                    cfg_write,
    input  logic [fe2eq_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [fe2eq_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // s_tdata: map_column [12:0], map_row [25:13], zero [31:26]
    input  logic [fe2eq_pkg::S_TDATA_BITS-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // m_tdata: source_x [17:0], source_y [35:18], zero [39:36]
    output logic [fe2eq_pkg::M_TDATA_BITS-1:0]      m_tdata
);
    import fe2eq_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [13:0] map_columns_reg;
    logic [13:0] map_rows_reg;
    logic [12:0] span_width_reg;
    logic [12:0] span_height_reg;
    logic [10:0] crop_margin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_columns_reg <= 14'd1024;
            map_rows_reg    <= 14'd1024;
            span_width_reg  <= 13'd1024;
            span_height_reg <= 13'd1024;
            crop_margin_reg <= 11'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAP_COLUMNS: map_columns_reg <= cfg_data;
                REG_MAP_ROWS:    map_rows_reg    <= cfg_data;
                REG_SPAN_WIDTH:  span_width_reg  <= cfg_data[12:0];
                REG_SPAN_HEIGHT: span_height_reg <= cfg_data[12:0];
                REG_CROP_MARGIN: crop_margin_reg <= cfg_data[10:0];
                default:         ;
            endcase
        end
    end

    // Effective sizes and spans
    logic [13:0]        cols_eff;
    logic [13:0]        rows_eff;
    logic [13:0]        col_lim;
    logic [13:0]        row_lim;
    logic signed [14:0] span_w_raw;
    logic signed [14:0] span_h_raw;
    logic [12:0]        span_x_reg;
    logic [12:0]        span_y_reg;

    assign cols_eff   = (map_columns_reg == '0) ? 14'd1 : map_columns_reg;
    assign rows_eff   = (map_rows_reg == '0) ? 14'd1 : map_rows_reg;
    assign col_lim    = cols_eff - 14'd1;
    assign row_lim    = rows_eff - 14'd1;
    assign span_w_raw = $signed({2'b00, span_width_reg})
                      - $signed({3'b000, crop_margin_reg, 1'b0});
    assign span_h_raw = $signed({2'b00, span_height_reg})
                      - $signed({3'b000, crop_margin_reg, 1'b0});

    always_ff @(posedge clk)
    begin
        span_x_reg <= (span_w_raw < 15'sd1) ? 13'd1 : span_w_raw[12:0];
        span_y_reg <= (span_h_raw < 15'sd1) ? 13'd1 : span_h_raw[12:0];
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances unless a result is stuck
    // ------------------------------------------------------------------
    logic               en;
    logic [LATENCY-1:0] vld_reg;

    assign en       = !vld_reg[LATENCY-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LATENCY-2:0], s_tvalid};
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp and mirror the position
    // ------------------------------------------------------------------
    logic [13:0] col_in;
    logic [13:0] row_in;
    logic [13:0] col_cl;
    logic [13:0] row_cl;
    logic [13:0] xm_reg;
    logic [13:0] ym_reg;

    assign col_in = {1'b0, s_tdata[COORD_BITS-1:0]};
    assign row_in = {1'b0, s_tdata[2*COORD_BITS-1:COORD_BITS]};
    assign col_cl = (col_in > col_lim) ? col_lim : col_in;
    assign row_cl = (row_in > row_lim) ? row_lim : row_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xm_reg <= col_lim - col_cl;
            ym_reg <= row_lim - row_cl;
        end
    end

    // Stage 2: scale by pi ahead of the division by the map size
    logic [45:0] num_a_reg;
    logic [45:0] num_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_a_reg <= 46'(xm_reg) * 46'(PI_Q30);
            num_b_reg <= 46'(ym_reg) * 46'(PI_Q30);
        end
    end

    // Stages 3..34: angles A and B
    logic [31:0] ang_a;
    logic [31:0] ang_b;

    fe2eq_div u_div_a (
        .clk (clk),
        .en  (en),
        .num (64'(num_a_reg)),
        .den (32'(cols_eff)),
        .quo (ang_a)
    );

    fe2eq_div u_div_b (
        .clk (clk),
        .en  (en),
        .num (64'(num_b_reg)),
        .den (32'(rows_eff)),
        .quo (ang_b)
    );

    // Stages 35..64: cosine and sine
    logic signed [33:0] cos_a;
    logic signed [33:0] sin_a;
    logic signed [33:0] cos_b;
    logic signed [33:0] sin_b;

    fe2eq_rot u_rot_a (
        .clk     (clk),
        .en      (en),
        .angle   (ang_a),
        .cos_out (cos_a),
        .sin_out (sin_a)
    );

    fe2eq_rot u_rot_b (
        .clk     (clk),
        .en      (en),
        .angle   (ang_b),
        .cos_out (cos_b),
        .sin_out (sin_b)
    );

    // Stage 65: direction on the unit sphere
    logic signed [67:0] prod_cs;
    logic signed [67:0] prod_ss;
    logic signed [33:0] sx_reg;
    logic signed [33:0] sy_reg;
    logic signed [33:0] sz_reg;

    assign prod_cs = cos_a * sin_b;
    assign prod_ss = sin_a * sin_b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= -34'(prod_cs >>> 30);
            sy_reg <= 34'(prod_ss >>> 30);
            sz_reg <= cos_b;
        end
    end

    // Stage 66: squares
    logic signed [67:0] sq_x;
    logic signed [67:0] sq_z;
    logic [63:0]        sxx_reg;
    logic [63:0]        szz_reg;
    dir_t               dir1_reg;

    assign sq_x = sx_reg * sx_reg;
    assign sq_z = sz_reg * sz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxx_reg  <= sq_x[63:0];
            szz_reg  <= sq_z[63:0];
            dir1_reg <= '{sx: sx_reg, sy: sy_reg, sz: sz_reg};
        end
    end

    // Stage 67: sum of squares, direction delayed to meet the root
    logic [63:0] sum_reg;
    dir_t        dir_dly_reg [SQRT_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg        <= sxx_reg + szz_reg;
            dir_dly_reg[0] <= dir1_reg;
            for (int i = 1; i <= SQRT_STEPS; i++)
                dir_dly_reg[i] <= dir_dly_reg[i-1];
        end
    end

    // Stages 68..99: radius in the x-z plane
    logic [31:0] rho;
    dir_t        dir_at_rho;

    fe2eq_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum_reg),
        .root     (rho)
    );

    assign dir_at_rho = dir_dly_reg[SQRT_STEPS];

    // Stages 100..130: polar angle; direction and radius ride alongside
    logic [32:0] alpha;
    dir_rho_t    dr_dly_reg [CORDIC_STEPS+1];
    dir_rho_t    dr_at_alpha;

    fe2eq_vec u_vec (
        .clk   (clk),
        .en    (en),
        .y_in  (rho),
        .x_in  (dir_at_rho.sy),
        .alpha (alpha)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dr_dly_reg[0] <= '{sx: dir_at_rho.sx, sz: dir_at_rho.sz, rho: rho};
            for (int i = 1; i <= CORDIC_STEPS; i++)
                dr_dly_reg[i] <= dr_dly_reg[i-1];
        end
    end

    assign dr_at_alpha = dr_dly_reg[CORDIC_STEPS];

    // Stages 131..162: normalised radius and direction cosines
    logic [33:0] mag_x;
    logic [33:0] mag_z;
    logic [31:0] q_r;
    logic [31:0] q_c;
    logic [31:0] q_s;
    sign_t       sgn_now;
    sign_t       sgn_dly_reg [DIV_STEPS];
    sign_t       sgn_at_q;

    assign mag_x = dr_at_alpha.sx[33] ? 34'(-dr_at_alpha.sx) : 34'(dr_at_alpha.sx);
    assign mag_z = dr_at_alpha.sz[33] ? 34'(-dr_at_alpha.sz) : 34'(dr_at_alpha.sz);

    assign sgn_now.neg_c    = dr_at_alpha.sx[33];
    assign sgn_now.neg_s    = !dr_at_alpha.sz[33] && (dr_at_alpha.sz != '0);
    assign sgn_now.rho_zero = (dr_at_alpha.rho == '0);

    // Radius over pi: estimate by the reciprocal (never above the true
    // quotient, at most two short), then correct against the remainder
    logic [63:0] r_mul_reg;
    logic [32:0] r_alpha_reg;
    logic [31:0] r_est_reg;
    logic [63:0] r_back_reg;
    logic [32:0] r_alpha2_reg;
    logic [63:0] r_rem;
    logic [31:0] r_fix_reg;
    logic [31:0] r_dly_reg [DIV_STEPS-RECIP_STEPS];

    assign r_rem = {1'b0, r_alpha2_reg, 30'b0} - r_back_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_mul_reg    <= 64'(alpha) * 64'(INV_PI_Q62);
            r_alpha_reg  <= alpha;
            r_est_reg    <= r_mul_reg[63:32];
            r_back_reg   <= 64'(r_mul_reg[63:32]) * 64'(PI_Q30);
            r_alpha2_reg <= r_alpha_reg;
            r_fix_reg    <= r_est_reg
                          + {31'b0, (r_rem >= 64'(PI_Q30))}
                          + {31'b0, (r_rem >= {31'b0, PI_Q30, 1'b0})};
            r_dly_reg[0] <= r_fix_reg;
            for (int i = 1; i < DIV_STEPS - RECIP_STEPS; i++)
                r_dly_reg[i] <= r_dly_reg[i-1];
        end
    end

    assign q_r = r_dly_reg[DIV_STEPS-RECIP_STEPS-1];

    fe2eq_div u_div_c (
        .clk (clk),
        .en  (en),
        .num ({mag_x, 30'b0}),
        .den (dr_at_alpha.rho),
        .quo (q_c)
    );

    fe2eq_div u_div_s (
        .clk (clk),
        .en  (en),
        .num ({mag_z, 30'b0}),
        .den (dr_at_alpha.rho),
        .quo (q_s)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgn_dly_reg[0] <= sgn_now;
            for (int i = 1; i < DIV_STEPS; i++)
                sgn_dly_reg[i] <= sgn_dly_reg[i-1];
        end
    end

    assign sgn_at_q = sgn_dly_reg[DIV_STEPS-1];

    // Stage 163: signs back on; undefined direction gives zero cosines
    logic signed [33:0] cth_reg;
    logic signed [33:0] sth_reg;
    logic [31:0]        r_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= q_r;
            if (sgn_at_q.rho_zero)
            begin
                cth_reg <= '0;
                sth_reg <= '0;
            end
            else
            begin
                cth_reg <= sgn_at_q.neg_c ? -$signed({2'b00, q_c}) : $signed({2'b00, q_c});
                sth_reg <= sgn_at_q.neg_s ? -$signed({2'b00, q_s}) : $signed({2'b00, q_s});
            end
        end
    end

    // Stage 164: radius times cosines
    logic signed [67:0] prod_rx;
    logic signed [67:0] prod_ry;
    logic signed [63:0] px_reg;
    logic signed [63:0] py_reg;

    assign prod_rx = $signed({2'b00, r_reg}) * cth_reg;
    assign prod_ry = $signed({2'b00, r_reg}) * sth_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= prod_rx[63:0];
            py_reg <= prod_ry[63:0];
        end
    end

    // Stage 165: recentre and scale by the span
    logic signed [34:0] tx;
    logic signed [34:0] ty;
    logic signed [48:0] mx_prod;
    logic signed [48:0] my_prod;
    logic signed [48:0] mx_reg;
    logic signed [48:0] my_reg;

    assign tx      = 35'((px_reg >>> 30) + $signed({32'b0, ONE_HALF_Q30}));
    assign ty      = 35'((py_reg >>> 30) + $signed({32'b0, ONE_HALF_Q30}));
    assign mx_prod = tx * $signed({1'b0, span_x_reg});
    assign my_prod = ty * $signed({1'b0, span_y_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= mx_prod;
            my_reg <= my_prod;
        end
    end

    // Stage 166: add crop, halve, round to 1/16 pixel, saturate
    logic signed [50:0] crop_q;
    logic signed [50:0] vx;
    logic signed [50:0] vy;
    logic signed [50:0] rx;
    logic signed [50:0] ry;
    logic [OUT_BITS-1:0] out_x_next;
    logic [OUT_BITS-1:0] out_y_next;
    logic [OUT_BITS-1:0] out_x_reg;
    logic [OUT_BITS-1:0] out_y_reg;

    assign crop_q = $signed({10'b0, crop_margin_reg, 30'b0});
    assign vx     = 51'(mx_reg) + crop_q + (51'sd1 <<< (30 - FRAC_BITS));
    assign vy     = 51'(my_reg) + crop_q + (51'sd1 <<< (30 - FRAC_BITS));
    assign rx     = vx >>> (31 - FRAC_BITS);
    assign ry     = vy >>> (31 - FRAC_BITS);

    always_comb
    begin
        if (rx > 51'sd131071)
            out_x_next = 18'h1FFFF;
        else if (rx < -51'sd131072)
            out_x_next = 18'h20000;
        else
            out_x_next = rx[OUT_BITS-1:0];

        if (ry > 51'sd131071)
            out_y_next = 18'h1FFFF;
        else if (ry < -51'sd131072)
            out_y_next = 18'h20000;
        else
            out_y_next = ry[OUT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    assign m_tdata = {4'b0000, out_y_reg, out_x_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while a result is stuck");

    a_accept_enters_pipe: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    a_freeze_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule
